// File: src/tsm_pkg.sv
// ----------------------------------------------------------------------------
// Timer slot manager package
// Shared types, operation codes and status codes.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int SLOT_W = 6;
    localparam int TIME_W = 32;
    localparam int WIN_W  = 16;
    localparam int STAT_W = 3;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_EXPIRE = 2'd3;

    localparam logic [STAT_W-1:0] ST_ARMED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_LAZY     = 3'd1;
    localparam logic [STAT_W-1:0] ST_DISARMED = 3'd2;
    localparam logic [STAT_W-1:0] ST_TIME     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EXPIRED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE     = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              armed;
        logic [SLOT_W-1:0] id;
        logic [TIME_W-1:0] deadline;
    } cell_t;

endpackage

// File: src/timer_slot_manager.sv
// ----------------------------------------------------------------------------
// Timer slot manager
// Arm, disarm and query rotate the whole slot ring once, one shift per slot,
// then load the result in the emit state once the output is free; the next
// item is taken only after that load, back in idle. Expire takes one ring
// pass per due slot plus one.
// The ring pass, one slot per cycle at the head cell, sets the rate.
// Reset clears all armed flags and the lazy window; deadlines are not reset.
// ----------------------------------------------------------------------------
module timer_slot_manager #(
    parameter int SLOTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tsm_pkg::OP_W-1:0]    opcode,
    input  logic [tsm_pkg::SLOT_W-1:0]  slot,
    input  logic [tsm_pkg::TIME_W-1:0]  delay_ms,
    input  logic [tsm_pkg::TIME_W-1:0]  now_ms,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tsm_pkg::STAT_W-1:0]  status,
    output logic [tsm_pkg::SLOT_W-1:0]  slot_out,
    output logic [tsm_pkg::TIME_W-1:0]  time_left,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tsm_pkg::WIN_W-1:0]   lazy_window
);
    import tsm_pkg::*;

    localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    cell_t cell_q [SLOTS];
    cell_t head_mod;
    logic  shift_en;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [OP_W-1:0]    op_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [TIME_W-1:0]  key_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [WIN_W-1:0]   window_reg;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  best_id_reg, best_id_next;
    logic [TIME_W-1:0]  bd_reg, bd_next;
    logic               lazy_reg, lazy_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]  pend_id_reg, pend_id_next;
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [SLOT_W-1:0]  slot_out_reg, slot_out_next;
    logic [TIME_W-1:0]  time_left_reg, time_left_next;
    logic               last_reg, last_next;
    logic               out_load;

    logic [TIME_W-1:0]  diff;
    logic [TIME_W-1:0]  mag;
    logic [TIME_W-1:0]  head_dist;
    logic               hit;
    logic               in_range;
    logic               due;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_ring
            cell_t d_in;
            if (gi == SLOTS - 1)
            begin : g_tail
                assign d_in = head_mod;
            end
            else
            begin : g_mid
                assign d_in = cell_q[gi+1];
            end
            tsm_cell #(.ID(gi)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d_in     (d_in),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    assign shift_en  = (state_reg == S_SCAN);
    assign hit       = (cell_q[0].id == slot_reg);
    assign in_range  = (32'(slot_reg) < SLOTS);
    assign diff      = key_reg - cell_q[0].deadline;
    assign mag       = diff[TIME_W-1] ? (~diff + 1'b1) : diff;
    assign head_dist = head_mod.deadline - now_reg;
    assign due       = found_reg && (bd_reg[TIME_W-1] || (bd_reg == '0));

    always_comb
    begin
        head_mod  = cell_q[0];
        lazy_next = lazy_reg;
        if (state_reg == S_SCAN)
        begin
            unique case (op_reg)
                OP_ARM:
                begin
                    if (hit)
                    begin
                        if (cell_q[0].armed && (mag < 32'(window_reg)))
                        begin
                            lazy_next = 1'b1;
                        end
                        else
                        begin
                            head_mod.armed    = 1'b1;
                            head_mod.deadline = key_reg;
                        end
                    end
                end
                OP_DISARM:
                begin
                    if (hit)
                    begin
                        head_mod.armed = 1'b0;
                    end
                end
                OP_EXPIRE:
                begin
                    if (pend_valid_reg && (cell_q[0].id == pend_id_reg))
                    begin
                        head_mod.armed = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        best_id_next    = best_id_reg;
        bd_next         = bd_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg;
        out_load        = 1'b0;
        status_next     = status_reg;
        slot_out_next   = slot_out_reg;
        time_left_next  = time_left_reg;
        last_next       = last_reg;
        in_ready        = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next      = S_SCAN;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (head_mod.armed &&
                    (!found_reg || ($signed(head_dist) < $signed(bd_reg))))
                begin
                    found_next   = 1'b1;
                    best_id_next = head_mod.id;
                    bd_next      = head_dist;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if ((op_reg == OP_EXPIRE) && !pend_valid_reg && due)
                begin
                    pend_valid_next = 1'b1;
                    pend_id_next    = best_id_reg;
                    state_next      = S_SCAN;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    slot_out_next  = slot_reg;
                    time_left_next = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    unique case (op_reg)
                        OP_ARM:
                        begin
                            if (!in_range)
                            begin
                                status_next = ST_DISARMED;
                            end
                            else if (lazy_reg)
                            begin
                                status_next = ST_LAZY;
                            end
                            else
                            begin
                                status_next = ST_ARMED;
                            end
                        end
                        OP_DISARM:
                        begin
                            status_next = ST_DISARMED;
                        end
                        OP_QUERY:
                        begin
                            status_next = ST_TIME;
                            if (!found_reg)
                            begin
                                slot_out_next  = '0;
                                time_left_next = '1;
                            end
                            else
                            begin
                                slot_out_next  = best_id_reg;
                                time_left_next = due ? '0 : bd_reg;
                            end
                        end
                        OP_EXPIRE:
                        begin
                            if (!pend_valid_reg)
                            begin
                                status_next   = ST_NONE;
                                slot_out_next = '0;
                            end
                            else
                            begin
                                status_next   = ST_EXPIRED;
                                slot_out_next = pend_id_reg;
                                last_next     = !due;
                                if (due)
                                begin
                                    pend_id_next = best_id_reg;
                                    state_next   = S_SCAN;
                                    cnt_next     = '0;
                                    found_next   = 1'b0;
                                end
                                else
                                begin
                                    pend_valid_next = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            lazy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            window_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (in_valid && in_ready)
            begin
                lazy_reg <= 1'b0;
            end
            else
            begin
                lazy_reg <= lazy_next;
            end
            if (cfg_valid)
            begin
                window_reg <= lazy_window;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_id_reg <= best_id_next;
        bd_reg      <= bd_next;
        pend_id_reg <= pend_id_next;
        if (in_valid && in_ready)
        begin
            op_reg   <= opcode;
            slot_reg <= slot;
            key_reg  <= now_ms + delay_ms;
            now_reg  <= now_ms;
        end
        if (out_load)
        begin
            status_reg    <= status_next;
            slot_out_reg  <= slot_out_next;
            time_left_reg <= time_left_next;
            last_reg      <= last_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign time_left = time_left_reg;
    assign last      = last_reg;

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SCAN) && (cnt_reg == '0))
        else $error("accepted item did not start a ring pass");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending expiry left over in idle");

    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_NONE || status == ST_TIME)) |-> last)
        else $error("single result beat without last");

endmodule

// File: src/tsm_cell.sv
// ----------------------------------------------------------------------------
// Timer slot cell
// One entry of the rotating slot ring: armed flag, slot number and deadline.
// ----------------------------------------------------------------------------
module tsm_cell #(
    parameter int ID = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  tsm_pkg::cell_t d_in,
    output tsm_pkg::cell_t q
);
    import tsm_pkg::*;

    logic              armed_reg;
    logic [SLOT_W-1:0] id_reg;
    logic [TIME_W-1:0] deadline_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            id_reg    <= SLOT_W'(ID);
        end
        else if (shift_en)
        begin
            armed_reg <= d_in.armed;
            id_reg    <= d_in.id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            deadline_reg <= d_in.deadline;
        end
    end

    assign q.armed    = armed_reg;
    assign q.id       = id_reg;
    assign q.deadline = deadline_reg;

endmodule

// File: tb/timer_slot_manager_test.sv
// ----------------------------------------------------------------------------
// Timer slot manager testbench
// Drives arm, disarm, query and expire beats with random gaps and output
// stalls, predicts every result from a model of the slot table and the lazy
// window, and checks each result beat field by field in order.
// ----------------------------------------------------------------------------
module timer_slot_manager_test;

    import tsm_pkg::*;

    localparam int NSLOT = 64;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_out;
        logic [TIME_W-1:0] time_left;
        logic              last;
    } result_t;

    class timer_scoreboard;
        bit                armed[NSLOT];
        logic [TIME_W-1:0] deadline[NSLOT];
        logic [WIN_W-1:0]  window;
        result_t           pending[$];
        int                errors;

        function void clear();
            foreach (armed[i]) armed[i] = 0;
            window = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void push(logic [STAT_W-1:0] st, int sl, logic [TIME_W-1:0] tl, bit lst);
            result_t r;
            r.status = st;
            r.slot_out = SLOT_W'(sl);
            r.time_left = tl;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function int earliest(logic [TIME_W-1:0] now, output int signed best_dist);
            int best;
            int signed d;
            best = -1;
            best_dist = 0;
            for (int s = 0; s < NSLOT; s++) begin
                if (armed[s]) begin
                    d = signed'(deadline[s] - now);
                    if (best < 0 || d < best_dist) begin
                        best = s;
                        best_dist = d;
                    end
                end
            end
            return best;
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] sl,
                                logic [TIME_W-1:0] dly, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] key, diff, mag;
            int s, n;
            int signed d;
            if (op == OP_DISARM || (op == OP_ARM && sl >= NSLOT)) begin
                if (sl < NSLOT) armed[sl] = 0;
                push(ST_DISARMED, sl, '0, 1);
            end else if (op == OP_ARM) begin
                key = now + dly;
                if (armed[sl]) begin
                    diff = key - deadline[sl];
                    mag = diff[31] ? -diff : diff;
                    if (mag < {16'd0, window}) begin
                        push(ST_LAZY, sl, '0, 1);
                        return;
                    end
                end
                deadline[sl] = key;
                armed[sl] = 1;
                push(ST_ARMED, sl, '0, 1);
            end else if (op == OP_QUERY) begin
                s = earliest(now, d);
                if (s < 0) push(ST_TIME, 0, '1, 1);
                else push(ST_TIME, s, d > 0 ? d : 0, 1);
            end else begin
                n = 0;
                forever begin
                    s = earliest(now, d);
                    if (s < 0 || d > 0) break;
                    armed[s] = 0;
                    push(ST_EXPIRED, s, '0, 0);
                    n++;
                end
                if (n == 0) push(ST_NONE, 0, '0, 1);
                else pending[$].last = 1;
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result beat, status %0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.slot_out !== e.slot_out) begin
                $error("slot_out: expected %0d, got %0d", e.slot_out, got.slot_out);
                errors++;
            end
            if (got.time_left !== e.time_left) begin
                $error("time_left: expected %h, got %h", e.time_left, got.time_left);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] delay_ms;
    logic [TIME_W-1:0] now_ms;
    logic              out_valid;
    logic              out_ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_out;
    logic [TIME_W-1:0] time_left;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [WIN_W-1:0]  lazy_window;

    timer_scoreboard   board;
    logic [TIME_W-1:0] clock_ms;
    int                hold_cycles;
    int                stall_mode;
    int                burst_left;

    timer_slot_manager #(.SLOTS(NSLOT)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .slot        (slot),
        .delay_ms    (delay_ms),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_out    (slot_out),
        .time_left   (time_left),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .lazy_window (lazy_window)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Sender offers one beat; gaps come from the burst counter.
    task automatic send_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] sl,
                             logic [TIME_W-1:0] dly, logic [TIME_W-1:0] now);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
        in_valid <= 1'b1;
        opcode   <= op;
        slot     <= sl;
        delay_ms <= dly;
        now_ms   <= now;
        do @(posedge clk); while (!in_ready);
        board.note_item(op, sl, dly, now);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (3 * NSLOT) @(posedge clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] w);
        cfg_valid   <= 1'b1;
        lazy_window <= w;
        do @(posedge clk); while (!cfg_ready);
        board.window = w;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        logic [SLOT_W-1:0] sl;
        logic [TIME_W-1:0] dly;
        pick = $urandom_range(0, 99);
        sl = $urandom_range(0, 15) == 0 ? SLOT_W'($urandom) : SLOT_W'($urandom_range(0, 11));
        case ($urandom_range(0, 5))
            0: dly = $urandom;
            1: dly = '0;
            default: dly = $urandom_range(0, 400);
        endcase
        clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 300) : 0;
        if (pick < 45) send_item(OP_ARM, sl, dly, clock_ms);
        else if (pick < 58) send_item(OP_DISARM, sl, dly, clock_ms);
        else if (pick < 78) send_item(OP_QUERY, SLOT_W'($urandom), $urandom, clock_ms);
        else send_item(OP_EXPIRE, SLOT_W'($urandom), $urandom, clock_ms);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready)
                board.check_result('{status, slot_out, time_left, last});
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    initial
    begin
        board = new();
        board.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_ARM;
        slot = '0;
        delay_ms = '0;
        now_ms = '0;
        cfg_valid = 1'b0;
        lazy_window = '0;
        hold_cycles = 0;
        stall_mode = 0;
        burst_left = 0;
        clock_ms = 32'hFFFF_FF00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats covering empty table, field extremes and wrap.
        send_item(OP_QUERY, '0, '0, '0);
        send_item(OP_EXPIRE, '1, '1, '1);
        send_item(OP_ARM, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_ARM, 6'd0, 32'h0000_0000, 32'h0000_0010);
        send_item(OP_ARM, 6'd1, 32'h0000_0010, 32'h0000_0000);
        send_item(OP_ARM, 6'd0, 32'h8000_0000, 32'h0000_0010);
        send_item(OP_QUERY, '1, '0, 32'h0000_0000);
        send_item(OP_QUERY, '0, '0, 32'h0000_0100);
        send_item(OP_ARM, 6'd2, 32'h7FFF_FFFF, 32'h0000_0100);
        send_item(OP_EXPIRE, '0, '0, 32'h0000_0100);
        send_item(OP_DISARM, 6'd2, '1, '0);
        send_item(OP_DISARM, 6'd2, '0, '0);
        send_item(OP_EXPIRE, '0, '0, 32'h8000_0200);
        send_item(OP_QUERY, '0, '0, 32'h8000_0200);
        drain();
        write_window(16'hFFFF);
        send_item(OP_ARM, 6'd5, 32'd100, 32'd1000);
        send_item(OP_ARM, 6'd5, 32'd300, 32'd1000);
        send_item(OP_ARM, 6'd5, 32'h0001_0000, 32'd1000);
        send_item(OP_ARM, 6'd6, 32'd1100, '0);
        send_item(OP_ARM, 6'd6, 32'd0, 32'h0001_FFFF);
        send_item(OP_EXPIRE, '0, '0, 32'h0002_0000);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_window(16'd0);
                1: write_window(16'd1);
                2: write_window(WIN_W'($urandom_range(50, 500)));
                default: write_window(16'hFFFF);
            endcase
            stall_mode = ph % 3;
            for (int i = 0; i < 85; i++) begin
                if (i == 40) hold_cycles = 2000;
                random_item();
                if (i == 60) drain();
            end
            drain();
        end

        if (board.errors == 0)
            $display("** timer_slot_manager: PASSED **");
        else
            $display("** timer_slot_manager: FAILED **");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("** timer_slot_manager: FAILED **");
        $finish;
    end

endmodule

// File: files.f
src/tsm_pkg.sv
src/tsm_cell.sv
src/timer_slot_manager.sv
tb/timer_slot_manager_test.sv
